[rtl/ps2hcq_pkg.sv]
package ps2hcq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	// keyboard protocol bytes
	localparam logic [7:0] KB_ACK       = 8'hFA;
	localparam logic [7:0] KB_RESEND    = 8'hFE;
	localparam logic [7:0] KB_BAT_OK    = 8'hAA;
	localparam logic [7:0] KB_BAT_FAIL1 = 8'hFC;
	localparam logic [7:0] KB_BAT_FAIL2 = 8'hFD;

	localparam logic [7:0] CMD_SET_LEDS  = 8'hED;
	localparam logic [7:0] CMD_SCAN_SET  = 8'hF0;
	localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
	localparam logic [7:0] CMD_ENABLE    = 8'hF4;
	localparam logic [7:0] CMD_KEY_MAKE  = 8'hFB;
	localparam logic [7:0] CMD_KEY_MB    = 8'hFC;
	localparam logic [7:0] CMD_KEY_MAKE2 = 8'hFD;

	// event kinds
	localparam logic [1:0] KIND_QUEUE = 2'd0;
	localparam logic [1:0] KIND_RX    = 2'd1;
	localparam logic [1:0] KIND_LOCK  = 2'd2;

	// register map (word index)
	localparam logic [1:0] REG_MAX_RESENDS = 2'd0;
	localparam logic [1:0] REG_SCAN_SET    = 2'd1;
	localparam logic [1:0] REG_TYPEMATIC   = 2'd2;

	localparam logic [2:0] MAX_RESENDS_RST = 3'd3;
	localparam logic [1:0] SCAN_SET_RST    = 2'd2;
	localparam logic [6:0] TYPEMATIC_RST   = 7'h20;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] cmd_byte;
		logic [7:0] arg_byte;
		logic [7:0] rx_byte;
		logic [1:0] lock_select;
		logic       lock_action;
	} ev_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       push_dropped;
		logic [2:0] led_bits;
		logic [4:0] queue_level;
		logic       awaiting_ack;
	} res_item_t;

	typedef struct packed {
		logic [2:0] max_resends;
		logic [1:0] scan_set;
		logic [6:0] typematic_value;
	} cfg_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_PUSH,
		UOP_READ,
		UOP_SEND_OP,
		UOP_SEND_ARG,
		UOP_RETIRE,
		UOP_RETRY,
		UOP_LOCK,
		UOP_FINISH
	} uop_t;

	typedef enum logic [2:0] {
		SRC_INPUT,
		SRC_SCAN,
		SRC_TYPM,
		SRC_ENBL,
		SRC_LEDS
	} push_src_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOT_WAIT,
		C_WAITING,
		C_TAKES_ARG,
		C_LOCK_PUSH,
		C_RETRY_OK,
		C_FILL_GT1
	} cond_t;

	typedef struct packed {
		logic      start;
		uop_t      op;
		push_src_t src;
	} ctl_t;

	typedef struct packed {
		logic waiting;
		logic takes_arg;
		logic lock_push;
		logic retry_ok;
		logic fill_gt1;
	} dp_flags_t;

	typedef struct packed {
		logic [1:0] tx_n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       dropped;
		logic [2:0] leds;
		logic [4:0] level;
		logic       waiting;
	} res_pack_t;

endpackage

[rtl/ps2hcq_seq.sv]
module ps2hcq_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid,
	output logic                  ev_stall,
	input  ps2hcq_pkg::ev_item_t  ev_data,
	input  ps2hcq_pkg::dp_flags_t flags,
	input  logic                  ob_free,
	output logic                  ob_load,
	output ps2hcq_pkg::ctl_t      ctl
);
	import ps2hcq_pkg::*;

	localparam int PC_W = 5;

	typedef struct packed {
		uop_t            op;
		push_src_t       src;
		cond_t           cond;
		logic [PC_W-1:0] tgt_t;
		logic [PC_W-1:0] tgt_f;
	} uword_t;

	// program entry points
	localparam logic [PC_W-1:0] ST_DONE  = 5'd0;
	localparam logic [PC_W-1:0] ST_SEND0 = 5'd1;
	localparam logic [PC_W-1:0] ST_SEND1 = 5'd2;
	localparam logic [PC_W-1:0] ST_SEND2 = 5'd3;
	localparam logic [PC_W-1:0] ST_PUSH  = 5'd4;
	localparam logic [PC_W-1:0] ST_BAT0  = 5'd5;
	localparam logic [PC_W-1:0] ST_BAT1  = 5'd6;
	localparam logic [PC_W-1:0] ST_BAT2  = 5'd7;
	localparam logic [PC_W-1:0] ST_BAT3  = 5'd8;
	localparam logic [PC_W-1:0] ST_LOCK0 = 5'd9;
	localparam logic [PC_W-1:0] ST_LOCK1 = 5'd10;
	localparam logic [PC_W-1:0] ST_ACK0  = 5'd11;
	localparam logic [PC_W-1:0] ST_ACK1  = 5'd12;
	localparam logic [PC_W-1:0] ST_RSD0  = 5'd13;
	localparam logic [PC_W-1:0] ST_RSD1  = 5'd14;
	localparam logic [PC_W-1:0] ST_RSD2  = 5'd15;
	localparam logic [PC_W-1:0] ST_RSD3  = 5'd16;

	function automatic uword_t mk(uop_t op, push_src_t src, cond_t cond,
			logic [PC_W-1:0] tt, logic [PC_W-1:0] tf);
		uword_t w;
		w.op    = op;
		w.src   = src;
		w.cond  = cond;
		w.tgt_t = tt;
		w.tgt_f = tf;
		return w;
	endfunction

	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			ST_SEND0: w = mk(UOP_READ,     SRC_INPUT, C_ALWAYS,    ST_SEND1, ST_SEND1);
			ST_SEND1: w = mk(UOP_SEND_OP,  SRC_INPUT, C_TAKES_ARG, ST_SEND2, ST_DONE);
			ST_SEND2: w = mk(UOP_SEND_ARG, SRC_INPUT, C_ALWAYS,    ST_DONE,  ST_DONE);
			ST_PUSH:  w = mk(UOP_PUSH,     SRC_INPUT, C_NOT_WAIT,  ST_SEND0, ST_DONE);
			ST_BAT0:  w = mk(UOP_PUSH,     SRC_SCAN,  C_ALWAYS,    ST_BAT1,  ST_BAT1);
			ST_BAT1:  w = mk(UOP_PUSH,     SRC_TYPM,  C_ALWAYS,    ST_BAT2,  ST_BAT2);
			ST_BAT2:  w = mk(UOP_PUSH,     SRC_ENBL,  C_ALWAYS,    ST_BAT3,  ST_BAT3);
			ST_BAT3:  w = mk(UOP_PUSH,     SRC_LEDS,  C_NOT_WAIT,  ST_SEND0, ST_DONE);
			ST_LOCK0: w = mk(UOP_LOCK,     SRC_INPUT, C_LOCK_PUSH, ST_LOCK1, ST_DONE);
			ST_LOCK1: w = mk(UOP_PUSH,     SRC_LEDS,  C_NOT_WAIT,  ST_SEND0, ST_DONE);
			ST_ACK0:  w = mk(UOP_NOP,      SRC_INPUT, C_WAITING,   ST_ACK1,  ST_DONE);
			ST_ACK1:  w = mk(UOP_RETIRE,   SRC_INPUT, C_FILL_GT1,  ST_SEND0, ST_DONE);
			ST_RSD0:  w = mk(UOP_NOP,      SRC_INPUT, C_WAITING,   ST_RSD1,  ST_DONE);
			ST_RSD1:  w = mk(UOP_NOP,      SRC_INPUT, C_RETRY_OK,  ST_RSD2,  ST_RSD3);
			ST_RSD2:  w = mk(UOP_RETRY,    SRC_INPUT, C_ALWAYS,    ST_SEND0, ST_SEND0);
			ST_RSD3:  w = mk(UOP_RETIRE,   SRC_INPUT, C_FILL_GT1,  ST_SEND0, ST_DONE);
			default:  w = mk(UOP_FINISH,   SRC_INPUT, C_ALWAYS,    ST_DONE,  ST_DONE);
		endcase
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry(ev_item_t ev);
		logic [PC_W-1:0] e;
		e = ST_DONE;
		if (ev.kind == KIND_QUEUE) begin
			e = ST_PUSH;
		end else if (ev.kind == KIND_LOCK) begin
			e = ST_LOCK0;
		end else if (ev.kind == KIND_RX) begin
			if (ev.rx_byte == KB_ACK) begin
				e = ST_ACK0;
			end else if (ev.rx_byte == KB_RESEND) begin
				e = ST_RSD0;
			end else if (ev.rx_byte == KB_BAT_OK || ev.rx_byte == KB_BAT_FAIL1 ||
					ev.rx_byte == KB_BAT_FAIL2) begin
				e = ST_BAT0;
			end
		end
		return e;
	endfunction

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	uword_t          word;
	logic            cond_ok;
	logic            accept;

	assign word     = ucode(pc_q);
	assign ev_stall = busy_q;
	assign accept   = ev_valid && !busy_q;

	always_comb begin
		unique case (word.cond)
			C_ALWAYS:    cond_ok = 1'b1;
			C_NOT_WAIT:  cond_ok = !flags.waiting;
			C_WAITING:   cond_ok = flags.waiting;
			C_TAKES_ARG: cond_ok = flags.takes_arg;
			C_LOCK_PUSH: cond_ok = flags.lock_push;
			C_RETRY_OK:  cond_ok = flags.retry_ok;
			C_FILL_GT1:  cond_ok = flags.fill_gt1;
			default:     cond_ok = 1'b0;
		endcase
	end

	assign ctl.start = accept;
	assign ctl.op    = busy_q ? word.op : UOP_NOP;
	assign ctl.src   = word.src;
	assign ob_load   = busy_q && (word.op == UOP_FINISH) && ob_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= ST_DONE;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= entry(ev_data);
		end else if (busy_q) begin
			if (word.op == UOP_FINISH) begin
				// hold until the result buffer can take the words
				if (ob_free) begin
					busy_q <= 1'b0;
				end
			end else begin
				pc_q <= cond_ok ? word.tgt_t : word.tgt_f;
			end
		end
	end

endmodule

[rtl/ps2hcq_dpath.sv]
module ps2hcq_dpath #(
	parameter int QUEUE_DEPTH = ps2hcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ps2hcq_pkg::ctl_t      ctl,
	input  ps2hcq_pkg::ev_item_t  ev_data,
	input  ps2hcq_pkg::cfg_t      cfg,
	output ps2hcq_pkg::dp_flags_t flags,
	output ps2hcq_pkg::res_pack_t pack
);
	import ps2hcq_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KS_RELEASED,
		KS_PRESSED,
		KS_REPEAT
	} key_state_t;

	logic [7:0]        op_mem  [QUEUE_DEPTH];
	logic [7:0]        arg_mem [QUEUE_DEPTH];

	ev_item_t          item_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;
	logic              waiting_q;
	logic [2:0]        retry_q;
	logic [2:0]        lock_on_q;
	logic [2:0]        fresh_q;
	key_state_t        key_q [3];
	logic [7:0]        rd_op_q;
	logic [7:0]        rd_arg_q;
	logic [1:0]        tx_n_q;
	logic [7:0]        tx_b0_q;
	logic [7:0]        tx_b1_q;
	logic              dropped_q;

	logic              full;
	logic [7:0]        push_op;
	logic [7:0]        push_arg;
	logic              sel_ok;
	logic [2:0]        lk_bit;
	key_state_t        ks_old;
	key_state_t        ks_new;
	logic [2:0]        lk_on_n;
	logic [2:0]        lk_fresh_n;
	logic              lk_push;
	logic [FILL_W+4:0] level_ext;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (fill_q == FILL_W'(QUEUE_DEPTH));

	always_comb begin
		unique case (ctl.src)
			SRC_INPUT: begin
				push_op  = item_q.cmd_byte;
				push_arg = item_q.arg_byte;
			end
			SRC_SCAN: begin
				push_op  = CMD_SCAN_SET;
				push_arg = {6'd0, cfg.scan_set};
			end
			SRC_TYPM: begin
				push_op  = CMD_TYPEMATIC;
				push_arg = {1'b0, cfg.typematic_value};
			end
			SRC_ENBL: begin
				push_op  = CMD_ENABLE;
				push_arg = 8'd0;
			end
			SRC_LEDS: begin
				push_op  = CMD_SET_LEDS;
				push_arg = {5'd0, lock_on_q};
			end
			default: begin
				push_op  = item_q.cmd_byte;
				push_arg = item_q.arg_byte;
			end
		endcase
	end

	// lock key: a lock set by this press survives the first release
	always_comb begin
		sel_ok     = (item_q.lock_select != 2'd3);
		lk_bit     = 3'b100 >> item_q.lock_select;
		ks_old     = sel_ok ? key_q[item_q.lock_select] : KS_RELEASED;
		lk_on_n    = lock_on_q;
		lk_fresh_n = fresh_q;
		lk_push    = 1'b0;
		if (item_q.lock_action) begin
			ks_new = KS_RELEASED;
		end else begin
			unique case (ks_old)
				KS_RELEASED: ks_new = KS_PRESSED;
				KS_PRESSED:  ks_new = KS_REPEAT;
				default:     ks_new = ks_old;
			endcase
		end
		if (sel_ok) begin
			if ((lock_on_q & lk_bit) != 3'd0) begin
				if (ks_new == KS_RELEASED) begin
					if ((fresh_q & lk_bit) == 3'd0) begin
						lk_on_n = lock_on_q & ~lk_bit;
						lk_push = 1'b1;
					end else begin
						lk_fresh_n = fresh_q & ~lk_bit;
					end
				end
			end else if (ks_new == KS_PRESSED) begin
				lk_on_n    = lock_on_q | lk_bit;
				lk_fresh_n = fresh_q | lk_bit;
				lk_push    = 1'b1;
			end
		end
	end

	assign flags.waiting   = waiting_q;
	assign flags.takes_arg = (rd_op_q == CMD_SET_LEDS) || (rd_op_q == CMD_SCAN_SET) ||
		(rd_op_q == CMD_TYPEMATIC) || (rd_op_q == CMD_KEY_MAKE) ||
		(rd_op_q == CMD_KEY_MB) || (rd_op_q == CMD_KEY_MAKE2);
	assign flags.lock_push = lk_push;
	assign flags.retry_ok  = (retry_q < cfg.max_resends);
	assign flags.fill_gt1  = (fill_q > FILL_W'(1));

	assign level_ext    = {5'd0, fill_q};
	assign pack.tx_n    = tx_n_q;
	assign pack.b0      = tx_b0_q;
	assign pack.b1      = tx_b1_q;
	assign pack.dropped = dropped_q;
	assign pack.leds    = lock_on_q;
	assign pack.level   = level_ext[4:0];
	assign pack.waiting = waiting_q;

	always_ff @(posedge clk) begin
		if (ctl.op == UOP_PUSH && !full) begin
			op_mem[tail_q]  <= push_op;
			arg_mem[tail_q] <= push_arg;
		end
		if (ctl.op == UOP_READ) begin
			rd_op_q  <= op_mem[head_q];
			rd_arg_q <= arg_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			item_q <= ev_data;
		end
		if (ctl.op == UOP_SEND_OP) begin
			tx_b0_q <= rd_op_q;
		end
		if (ctl.op == UOP_SEND_ARG) begin
			tx_b1_q <= rd_arg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			waiting_q <= 1'b0;
			retry_q   <= 3'd0;
			lock_on_q <= 3'd0;
			fresh_q   <= 3'd0;
			key_q[0]  <= KS_RELEASED;
			key_q[1]  <= KS_RELEASED;
			key_q[2]  <= KS_RELEASED;
			tx_n_q    <= 2'd0;
			dropped_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				tx_n_q    <= 2'd0;
				dropped_q <= 1'b0;
			end
			unique case (ctl.op)
				UOP_PUSH: begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						tail_q <= ptr_next(tail_q);
						fill_q <= fill_q + 1'b1;
					end
				end
				UOP_SEND_OP: begin
					waiting_q <= 1'b1;
					tx_n_q    <= 2'd1;
				end
				UOP_SEND_ARG: begin
					tx_n_q <= 2'd2;
				end
				UOP_RETIRE: begin
					waiting_q <= 1'b0;
					retry_q   <= 3'd0;
					head_q    <= ptr_next(head_q);
					if (fill_q != '0) begin
						fill_q <= fill_q - 1'b1;
					end
				end
				UOP_RETRY: begin
					retry_q <= retry_q + 3'd1;
				end
				UOP_LOCK: begin
					lock_on_q <= lk_on_n;
					fresh_q   <= lk_fresh_n;
					if (sel_ok) begin
						key_q[item_q.lock_select] <= ks_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/ps2hcq_obuf.sv]
module ps2hcq_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ps2hcq_pkg::res_pack_t pack,
	output logic                  free,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ps2hcq_pkg::res_item_t res_data
);
	import ps2hcq_pkg::*;

	logic      valid_q;
	logic      idx_q;
	res_pack_t pk_q;
	logic      last;
	logic      take;

	// one word when nothing was sent, otherwise one word per byte
	assign last      = (pk_q.tx_n == 2'd2) ? idx_q : 1'b1;
	assign take      = valid_q && !res_stall;
	assign free      = !valid_q || (take && last);
	assign res_valid = valid_q;

	assign res_data.tx_valid     = (pk_q.tx_n != 2'd0);
	assign res_data.tx_byte      = (pk_q.tx_n == 2'd0) ? 8'd0 : (idx_q ? pk_q.b1 : pk_q.b0);
	assign res_data.tx_last      = last;
	assign res_data.push_dropped = pk_q.dropped;
	assign res_data.led_bits     = pk_q.leds;
	assign res_data.queue_level  = pk_q.level;
	assign res_data.awaiting_ack = pk_q.waiting;

	always_ff @(posedge clk) begin
		if (load) begin
			pk_q <= pack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

endmodule

[rtl/ps2_host_command_queue_top.sv]
// PS/2 keyboard host command queue.
// Event channel (ev_valid/ev_stall/ev_data): queue a command, hand over a byte
// received from the keyboard, or report a lock key make/break.
// Result channel (res_valid/res_stall/res_data): each event yields one word, or
// one word per byte sent to the keyboard (at most two); tx_last marks the final
// word of an event and every word carries the status after the event.
// Registers on the APB port: 0x0 max_resends, 0x4 scan_set, 0x8 typematic_value.
// Each event runs a short program from the control store, one step a cycle
// except while held at its final step; the longest is for a self-test byte
// that finds the queue idle and sends the first command.
// The queue read takes a step of its own before each transmitted command.
// A finished event is parked in the result buffer; the next event is taken
// while the buffer waits. With res_stall high the sequencer holds at its final
// step until the buffer is free, and ev_stall stays high meanwhile.
// Reset empties the queue, clears the lock flags and loads register defaults.
module ps2_host_command_queue_top #(
	parameter int QUEUE_DEPTH = ps2hcq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid,
	output logic                  ev_stall,
	input  ps2hcq_pkg::ev_item_t  ev_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output ps2hcq_pkg::res_item_t res_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ps2hcq_pkg::*;

	cfg_t      cfg_q;
	ctl_t      ctl;
	dp_flags_t flags;
	res_pack_t pack;
	logic      ob_free;
	logic      ob_load;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_resends     <= MAX_RESENDS_RST;
			cfg_q.scan_set        <= SCAN_SET_RST;
			cfg_q.typematic_value <= TYPEMATIC_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MAX_RESENDS: cfg_q.max_resends     <= pwdata[2:0];
				REG_SCAN_SET:    cfg_q.scan_set        <= pwdata[1:0];
				REG_TYPEMATIC:   cfg_q.typematic_value <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_RESENDS: prdata = {29'd0, cfg_q.max_resends};
			REG_SCAN_SET:    prdata = {30'd0, cfg_q.scan_set};
			REG_TYPEMATIC:   prdata = {25'd0, cfg_q.typematic_value};
			default:         prdata = 32'd0;
		endcase
	end

	ps2hcq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_data  (ev_data),
		.flags    (flags),
		.ob_free  (ob_free),
		.ob_load  (ob_load),
		.ctl      (ctl)
	);

	ps2hcq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.ev_data (ev_data),
		.cfg     (cfg_q),
		.flags   (flags),
		.pack    (pack)
	);

	ps2hcq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ob_load),
		.pack      (pack),
		.free      (ob_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ps2hcq_pkg::*;

	localparam int DEPTH           = QUEUE_DEPTH_DEF;
	localparam int EV_W            = $bits(ev_item_t);
	localparam int QUIET_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 254;
	localparam int MAX_REPORTS     = 10;

	localparam logic [1:0] KIND_NONE  = 2'd3;
	localparam logic [1:0] SEL_CAPS   = 2'd0;
	localparam logic [1:0] SEL_NUM    = 2'd1;
	localparam logic [1:0] SEL_SCROLL = 2'd2;
	localparam logic [1:0] SEL_NONE   = 2'd3;
	localparam logic       ACT_MAKE   = 1'b0;
	localparam logic       ACT_BREAK  = 1'b1;

	typedef enum logic [1:0] {
		KEY_RELEASED,
		KEY_PRESSED,
		KEY_REPEAT
	} key_state_t;

	typedef struct {
		ev_item_t  ev;
		bit        typed;
		res_item_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        ev_valid;
	logic        ev_stall;
	ev_item_t    ev_data;
	logic        res_valid;
	logic        res_stall;
	res_item_t   res_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// mirror of the block's state
	logic [7:0] cmdq_op[$];
	logic [7:0] cmdq_arg[$];
	bit         cmd_pending = 1'b0;
	logic [2:0] resend_count = '0;
	logic [2:0] lock_leds = '0;
	logic [2:0] lock_fresh = '0;
	key_state_t key_st[3] = '{KEY_RELEASED, KEY_RELEASED, KEY_RELEASED};
	cfg_t       cfg = '{MAX_RESENDS_RST, SCAN_SET_RST, TYPEMATIC_RST};

	logic [7:0] sent_bytes[$];
	bit         push_lost;
	res_item_t  step_words[$];
	res_item_t  pending_words[$];

	dir_row_t   dir_rows[$];
	bit         row_typed = 1'b0;
	res_item_t  row_want = '0;
	int         gap_pct = 0;
	int         hold_pct = 0;
	int         fail_count = 0;
	int         quiet_cycles = 0;

	ps2_host_command_queue_top #(.QUEUE_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_data  (ev_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic string show(res_item_t w);
		return $sformatf("tx_valid=%0b tx_byte=%02h tx_last=%0b dropped=%0b leds=%03b level=%0d ack=%0b",
			w.tx_valid, w.tx_byte, w.tx_last, w.push_dropped, w.led_bits,
			w.queue_level, w.awaiting_ack);
	endfunction

	function automatic bit takes_arg(logic [7:0] op);
		return op == CMD_SET_LEDS || op == CMD_SCAN_SET || op == CMD_TYPEMATIC ||
			op == CMD_KEY_MAKE || op == CMD_KEY_MB || op == CMD_KEY_MAKE2;
	endfunction

	function automatic void emit(logic [7:0] b);
		if (sent_bytes.size() < 2)
			sent_bytes.push_back(b);
	endfunction

	function automatic void send_head();
		emit(cmdq_op[0]);
		if (takes_arg(cmdq_op[0]))
			emit(cmdq_arg[0]);
		cmd_pending = 1'b1;
	endfunction

	function automatic void push_cmd(logic [7:0] op, logic [7:0] arg);
		if (cmdq_op.size() >= DEPTH) begin
			push_lost = 1'b1;
			return;
		end
		cmdq_op.push_back(op);
		cmdq_arg.push_back(arg);
		if (!cmd_pending)
			send_head();
	endfunction

	function automatic void retire_head();
		cmd_pending = 1'b0;
		resend_count = '0;
		if (cmdq_op.size() > 0) begin
			void'(cmdq_op.pop_front());
			void'(cmdq_arg.pop_front());
		end
		if (cmdq_op.size() > 0)
			send_head();
	endfunction

	function automatic void take_reply(logic [7:0] b);
		case (b)
			KB_BAT_OK, KB_BAT_FAIL1, KB_BAT_FAIL2: begin
				push_cmd(CMD_SCAN_SET, {6'd0, cfg.scan_set});
				push_cmd(CMD_TYPEMATIC, {1'b0, cfg.typematic_value});
				push_cmd(CMD_ENABLE, 8'h00);
				push_cmd(CMD_SET_LEDS, {5'd0, lock_leds});
			end
			KB_ACK: begin
				if (cmd_pending)
					retire_head();
			end
			KB_RESEND: begin
				if (cmdq_op.size() > 0 && cmd_pending) begin
					if (resend_count < cfg.max_resends) begin
						send_head();
						resend_count = resend_count + 3'd1;
					end else begin
						retire_head();
					end
				end
			end
			default: ;
		endcase
	endfunction

	// a lock set by a press stays on through its first release
	function automatic void lock_key(logic [1:0] sel, logic act);
		logic [2:0] mask;
		if (sel == SEL_NONE)
			return;
		mask = 3'b100 >> sel;
		if (act == ACT_MAKE) begin
			if (key_st[sel] == KEY_PRESSED)
				key_st[sel] = KEY_REPEAT;
			else if (key_st[sel] == KEY_RELEASED)
				key_st[sel] = KEY_PRESSED;
		end else begin
			key_st[sel] = KEY_RELEASED;
		end
		if ((lock_leds & mask) != 0) begin
			if (key_st[sel] == KEY_RELEASED) begin
				if ((lock_fresh & mask) == 0) begin
					lock_leds = lock_leds & ~mask;
					push_cmd(CMD_SET_LEDS, {5'd0, lock_leds});
				end else begin
					lock_fresh = lock_fresh & ~mask;
				end
			end
		end else if (key_st[sel] == KEY_PRESSED) begin
			lock_leds = lock_leds | mask;
			lock_fresh = lock_fresh | mask;
			push_cmd(CMD_SET_LEDS, {5'd0, lock_leds});
		end
	endfunction

	function automatic void predict_words(ev_item_t ev);
		res_item_t w;
		int n;
		sent_bytes.delete();
		step_words.delete();
		push_lost = 1'b0;
		case (ev.kind)
			KIND_QUEUE: push_cmd(ev.cmd_byte, ev.arg_byte);
			KIND_RX:    take_reply(ev.rx_byte);
			KIND_LOCK:  lock_key(ev.lock_select, ev.lock_action);
			default: ;
		endcase
		n = sent_bytes.size() > 0 ? sent_bytes.size() : 1;
		for (int k = 0; k < n; k++) begin
			w.tx_valid     = sent_bytes.size() > 0;
			w.tx_byte      = sent_bytes.size() > 0 ? sent_bytes[k] : 8'h00;
			w.tx_last      = k == n - 1;
			w.push_dropped = push_lost;
			w.led_bits     = lock_leds;
			w.queue_level  = 5'(cmdq_op.size());
			w.awaiting_ack = cmd_pending;
			step_words.push_back(w);
		end
	endfunction

	function automatic void check_word(res_item_t got);
		res_item_t want;
		string diff;
		if (pending_words.size() == 0) begin
			note_failure({"unexpected word: ", show(got)});
			return;
		end
		want = pending_words.pop_front();
		diff = "";
		if (got.tx_valid !== want.tx_valid)         diff = {diff, " tx_valid"};
		if (got.tx_byte !== want.tx_byte)           diff = {diff, " tx_byte"};
		if (got.tx_last !== want.tx_last)           diff = {diff, " tx_last"};
		if (got.push_dropped !== want.push_dropped) diff = {diff, " push_dropped"};
		if (got.led_bits !== want.led_bits)         diff = {diff, " led_bits"};
		if (got.queue_level !== want.queue_level)   diff = {diff, " queue_level"};
		if (got.awaiting_ack !== want.awaiting_ack) diff = {diff, " awaiting_ack"};
		if (diff != "")
			note_failure($sformatf("word mismatch on%s\n  want %s\n  got  %s",
				diff, show(want), show(got)));
	endfunction

	// predict on the event edge before checking, so the order within the step never matters
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (ev_valid === 1'b1 && ev_stall === 1'b0) begin
				predict_words(ev_data);
				if (row_typed)
					pending_words.push_back(row_want);
				else
					foreach (step_words[k])
						pending_words.push_back(step_words[k]);
				quiet_cycles = 0;
			end
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				check_word(res_data);
				quiet_cycles = 0;
			end
			if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)
				quiet_cycles = 0;
		end
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall <= $urandom_range(99) < hold_pct;
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic ev_item_t mk_ev(logic [1:0] kind, logic [7:0] cmd, logic [7:0] arg,
		logic [7:0] rx, logic [1:0] sel, logic act);
		ev_item_t e;
		e.kind        = kind;
		e.cmd_byte    = cmd;
		e.arg_byte    = arg;
		e.rx_byte     = rx;
		e.lock_select = sel;
		e.lock_action = act;
		return e;
	endfunction

	function automatic res_item_t lone_word(logic v, logic [7:0] b, logic d, logic [2:0] leds,
		logic [4:0] lvl, logic ack);
		res_item_t w;
		w.tx_valid     = v;
		w.tx_byte      = b;
		w.tx_last      = 1'b1;
		w.push_dropped = d;
		w.led_bits     = leds;
		w.queue_level  = lvl;
		w.awaiting_ack = ack;
		return w;
	endfunction

	task automatic add_row(ev_item_t e, bit typed, res_item_t w);
		dir_row_t r;
		r.ev    = e;
		r.typed = typed;
		r.want  = w;
		dir_rows.push_back(r);
	endtask

	// mostly well-formed traffic: acks outweigh pushes so the queue both fills and drains
	function automatic ev_item_t random_event();
		ev_item_t e;
		int pick;
		int sub;
		e = ev_item_t'(EV_W'($urandom));
		pick = $urandom_range(99);
		if (pick < 20) begin
			e.kind = KIND_QUEUE;
			case ($urandom_range(8))
				0: e.cmd_byte = CMD_SET_LEDS;
				1: e.cmd_byte = CMD_SCAN_SET;
				2: e.cmd_byte = CMD_TYPEMATIC;
				3: e.cmd_byte = CMD_ENABLE;
				4: e.cmd_byte = CMD_KEY_MAKE;
				5: e.cmd_byte = CMD_KEY_MB;
				6: e.cmd_byte = CMD_KEY_MAKE2;
				default: ;
			endcase
		end else if (pick < 75) begin
			e.kind = KIND_RX;
			sub = $urandom_range(99);
			if (sub < 58)
				e.rx_byte = KB_ACK;
			else if (sub < 80)
				e.rx_byte = KB_RESEND;
			else if (sub < 84) begin
				case ($urandom_range(2))
					0: e.rx_byte = KB_BAT_OK;
					1: e.rx_byte = KB_BAT_FAIL1;
					default: e.rx_byte = KB_BAT_FAIL2;
				endcase
			end
		end else if (pick < 95) begin
			e.kind = KIND_LOCK;
			if ($urandom_range(19) != 0)
				e.lock_select = 2'($urandom_range(2));
		end
		return e;
	endfunction

	task automatic set_pace(int mode);
		case (mode)
			0: begin
				gap_pct = 38;
				hold_pct = 78;
			end
			1: begin
				gap_pct = 78;
				hold_pct = 38;
			end
			default: begin
				gap_pct = 0;
				hold_pct = 0;
			end
		endcase
	endtask

	// hold the word until it is taken; drop valid only while idling
	task automatic put_event(ev_item_t e, bit typed, res_item_t w);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			ev_valid <= 1'b0;
			@(negedge clk);
		end
		row_typed = typed;
		row_want = w;
		ev_valid <= 1'b1;
		ev_data <= e;
		do @(posedge clk); while (ev_stall !== 1'b0);
	endtask

	task automatic settle();
		@(negedge clk);
		ev_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(bit wr, logic [1:0] idx, logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		if (wr) begin
			case (idx)
				REG_MAX_RESENDS: cfg.max_resends = wdata[2:0];
				REG_SCAN_SET:    cfg.scan_set = wdata[1:0];
				REG_TYPEMATIC:   cfg.typematic_value = wdata[6:0];
				default: ;
			endcase
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		logic [31:0] rd;
		apb_xfer(1'b0, REG_MAX_RESENDS, '0, rd);
		if (rd[2:0] !== cfg.max_resends)
			note_failure($sformatf("max_resends reads %0d, want %0d", rd[2:0], cfg.max_resends));
		apb_xfer(1'b0, REG_SCAN_SET, '0, rd);
		if (rd[1:0] !== cfg.scan_set)
			note_failure($sformatf("scan_set reads %0d, want %0d", rd[1:0], cfg.scan_set));
		apb_xfer(1'b0, REG_TYPEMATIC, '0, rd);
		if (rd[6:0] !== cfg.typematic_value)
			note_failure($sformatf("typematic_value reads %02h, want %02h",
				rd[6:0], cfg.typematic_value));
	endtask

	initial begin
		res_item_t quiet;
		logic [31:0] mr;
		logic [31:0] ss;
		logic [31:0] tv;
		logic [31:0] rd;

		arst_n = 1'b0;
		ev_valid = 1'b0;
		ev_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_pace(0);
		check_registers();

		quiet = lone_word(1'b0, 8'h00, 1'b0, 3'd0, 5'd0, 1'b0);
		// replies with nothing outstanding, stray bytes and undefined codes
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_ACK, SEL_CAPS, ACT_MAKE), 1'b1, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_RESEND, SEL_CAPS, ACT_MAKE), 1'b1, quiet);
		add_row(mk_ev(KIND_RX, 8'hFF, 8'hFF, 8'hFF, SEL_NONE, ACT_BREAK), 1'b1, quiet);
		add_row(mk_ev(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, SEL_NONE, ACT_BREAK), 1'b1, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_NONE, ACT_MAKE), 1'b1, quiet);
		// commands: one sent at once, the rest wait behind it
		add_row(mk_ev(KIND_QUEUE, CMD_ENABLE, 8'hFF, 8'h00, SEL_CAPS, ACT_MAKE), 1'b1,
			lone_word(1'b1, CMD_ENABLE, 1'b0, 3'd0, 5'd1, 1'b1));
		add_row(mk_ev(KIND_QUEUE, CMD_SET_LEDS, 8'h00, 8'h00, SEL_CAPS, ACT_MAKE), 1'b1,
			lone_word(1'b0, 8'h00, 1'b0, 3'd0, 5'd2, 1'b1));
		add_row(mk_ev(KIND_QUEUE, 8'h00, 8'hFF, 8'h00, SEL_CAPS, ACT_MAKE), 1'b1,
			lone_word(1'b0, 8'h00, 1'b0, 3'd0, 5'd3, 1'b1));
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_RESEND, SEL_CAPS, ACT_MAKE), 1'b1,
			lone_word(1'b1, CMD_ENABLE, 1'b0, 3'd0, 5'd3, 1'b1));
		// run out of resends, then ack the rest
		repeat (3) add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_RESEND, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_ACK, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_ACK, SEL_CAPS, ACT_MAKE), 1'b1, quiet);
		// caps: press, repeat, release keeps it on, second press and release turn it off
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_CAPS, ACT_BREAK), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_CAPS, ACT_BREAK), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_NUM, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_LOCK, 8'h00, 8'h00, 8'h00, SEL_SCROLL, ACT_MAKE), 1'b0, quiet);
		// self-test while busy, until the queue overflows
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_BAT_OK, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_BAT_FAIL1, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_BAT_FAIL2, SEL_CAPS, ACT_MAKE), 1'b0, quiet);
		add_row(mk_ev(KIND_RX, 8'h00, 8'h00, KB_BAT_OK, SEL_CAPS, ACT_MAKE), 1'b0, quiet);

		foreach (dir_rows[i])
			put_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					mr = 32'd0;
					ss = 32'd1;
					tv = 32'd0;
				end
				1: begin
					mr = 32'd7;
					ss = 32'd3;
					tv = 32'd127;
				end
				2: begin
					mr = 32'd1;
					ss = 32'd0;
					tv = 32'h55;
				end
				default: begin
					mr = $urandom;
					ss = $urandom;
					tv = $urandom;
				end
			endcase
			apb_xfer(1'b1, REG_MAX_RESENDS, mr, rd);
			apb_xfer(1'b1, REG_SCAN_SET, ss, rd);
			apb_xfer(1'b1, REG_TYPEMATIC, tv, rd);
			check_registers();
			set_pace(p / 2);
			repeat (ITEMS_PER_PHASE) put_event(random_event(), 1'b0, quiet);
		end

		settle();
		if (fail_count == 0 && pending_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[ps2_host_command_queue_top.f]
rtl/ps2hcq_pkg.sv
rtl/ps2hcq_seq.sv
rtl/ps2hcq_dpath.sv
rtl/ps2hcq_obuf.sv
rtl/ps2_host_command_queue_top.sv
test/testbench.sv
